[src/gicl_pkg.sv]
// shared types and constants for the greedy increasing-chain layering block
package gicl_pkg;

   localparam int MAX_CHAINS_DEFAULT = 1024;
   localparam int KEY_BITS_DEFAULT   = 16;

   localparam int REQ_KEY_BITS   = 16;
   localparam int RSP_INDEX_BITS = 10;
   localparam int RSP_COUNT_BITS = 11;

   // depth of the queue between front and back
   localparam int QUEUE_DEPTH = 2;

   typedef struct packed {
      logic [REQ_KEY_BITS-1:0] key;
      logic                    first_of_sequence;
   } req_payload_type;

   typedef struct packed {
      logic [RSP_INDEX_BITS-1:0] chain_index;
      logic                      opened_chain;
      logic [RSP_COUNT_BITS-1:0] chain_count;
      logic                      overflow;
   } rsp_payload_type;

endpackage

[src/gicl_front.sv]
// front end: takes transactions, trims the key and queues them for the back end
module gicl_front #(
   parameter int KEY_BITS = gicl_pkg::KEY_BITS_DEFAULT
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  gicl_pkg::req_payload_type req_data,
   output logic                     q_valid,
   output logic [KEY_BITS-1:0]      q_key,
   output logic                     q_first,
   input  logic                     q_pop
);
   import gicl_pkg::*;

   localparam int PTR_BITS  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int FILL_BITS = $clog2(QUEUE_DEPTH + 1);

   logic [KEY_BITS-1:0]  key_q_ff   [QUEUE_DEPTH];
   logic                 first_q_ff [QUEUE_DEPTH];
   logic [PTR_BITS-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [FILL_BITS-1:0] fill_ff, fill_in;
   logic                 push;
   logic                 pop;

   assign busy    = (fill_ff == FILL_BITS'(QUEUE_DEPTH));
   assign push    = start && !busy;
   assign q_valid = (fill_ff != '0);
   assign pop     = q_pop && q_valid;
   assign q_key   = key_q_ff[rd_ptr_ff];
   assign q_first = first_q_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_BITS'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_BITS'(1);
      end
      unique case ({push, pop})
         2'b10:   fill_in = fill_ff + FILL_BITS'(1);
         2'b01:   fill_in = fill_ff - FILL_BITS'(1);
         default: fill_in = fill_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   // key is cut or widened to the stored key width
   always_ff @(posedge clock) begin
      if (push) begin
         key_q_ff[wr_ptr_ff]   <= KEY_BITS'(req_data.key);
         first_q_ff[wr_ptr_ff] <= req_data.first_of_sequence;
      end
   end

endmodule

[src/gicl_back.sv]
// back end: chain tail memory, binary search sequencer and result register
module gicl_back #(
   parameter int MAX_CHAINS = gicl_pkg::MAX_CHAINS_DEFAULT,
   parameter int KEY_BITS   = gicl_pkg::KEY_BITS_DEFAULT
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     q_valid,
   input  logic [KEY_BITS-1:0]      q_key,
   input  logic                     q_first,
   output logic                     q_pop,
   output logic                     rsp_strobe,
   output gicl_pkg::rsp_payload_type rsp_data
);
   import gicl_pkg::*;

   localparam int IW = $clog2(MAX_CHAINS);
   localparam int CW = $clog2(MAX_CHAINS + 1);

   typedef enum logic [2:0] {
      S_IDLE  = 3'b001,
      S_START = 3'b010,
      S_PROBE = 3'b100
   } back_state_type;

   back_state_type  state_ff, state_in;
   logic [KEY_BITS-1:0] key_ff, key_in;
   logic [KEY_BITS-1:0] newest_ff, newest_in;
   logic [CW-1:0]   count_ff, count_in;
   logic [IW-1:0]   lo_ff, lo_in;
   logic [IW-1:0]   hi_ff, hi_in;
   logic [IW-1:0]   mid_ff, mid_in;
   logic            rsp_strobe_ff, rsp_strobe_in;
   rsp_payload_type rsp_data_ff, rsp_data_in;

   logic [KEY_BITS-1:0] tails_mem [MAX_CHAINS];
   logic [KEY_BITS-1:0] rd_data_ff;

   logic                mem_we;
   logic                mem_re;
   logic [IW-1:0]       mem_waddr;
   logic [IW-1:0]       mem_raddr;
   logic [KEY_BITS-1:0] mem_wdata;

   logic [CW-1:0] cnt;
   logic [IW-1:0] lo_n;
   logic [IW-1:0] hi_n;
   logic [IW-1:0] mid_n;
   logic          fin_valid;
   logic [IW-1:0] fin_idx;

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_data_ff;

   always_comb begin
      state_in      = state_ff;
      key_in        = key_ff;
      newest_in     = newest_ff;
      count_in      = count_ff;
      lo_in         = lo_ff;
      hi_in         = hi_ff;
      mid_in        = mid_ff;
      rsp_strobe_in = 1'b0;
      rsp_data_in   = rsp_data_ff;
      mem_we        = 1'b0;
      mem_re        = 1'b0;
      mem_waddr     = '0;
      mem_raddr     = '0;
      mem_wdata     = '0;
      q_pop         = 1'b0;
      cnt           = count_ff;
      lo_n          = lo_ff;
      hi_n          = hi_ff;
      mid_n         = mid_ff;
      fin_valid     = 1'b0;
      fin_idx       = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (q_valid) begin
               q_pop    = 1'b1;
               key_in   = q_key;
               cnt      = q_first ? '0 : count_ff;
               count_in = cnt;
               if (cnt == '0 || q_key <= newest_ff) begin
                  rsp_strobe_in = 1'b1;
                  if (cnt >= CW'(MAX_CHAINS)) begin
                     // store full, key dropped
                     rsp_data_in.chain_index  = '0;
                     rsp_data_in.opened_chain = 1'b0;
                     rsp_data_in.chain_count  = RSP_COUNT_BITS'(cnt);
                     rsp_data_in.overflow     = 1'b1;
                  end else begin
                     mem_we    = 1'b1;
                     mem_waddr = IW'(cnt);
                     mem_wdata = q_key;
                     newest_in = q_key;
                     count_in  = cnt + CW'(1);
                     rsp_data_in.chain_index  = RSP_INDEX_BITS'(cnt);
                     rsp_data_in.opened_chain = 1'b1;
                     rsp_data_in.chain_count  = RSP_COUNT_BITS'(cnt + CW'(1));
                     rsp_data_in.overflow     = 1'b0;
                  end
               end else begin
                  lo_in    = '0;
                  hi_in    = IW'(cnt - CW'(1));
                  state_in = S_START;
               end
            end
         end
         S_START: begin
            if (lo_ff < hi_ff) begin
               mid_n     = lo_ff + ((hi_ff - lo_ff) >> 1);
               mem_re    = 1'b1;
               mem_raddr = mid_n;
               mid_in    = mid_n;
               state_in  = S_PROBE;
            end else begin
               fin_valid = 1'b1;
               fin_idx   = lo_ff;
            end
         end
         S_PROBE: begin
            // tails never increase, so a tail below the key moves hi down
            if (rd_data_ff < key_ff) begin
               lo_n = lo_ff;
               hi_n = mid_ff;
            end else begin
               lo_n = mid_ff + IW'(1);
               hi_n = hi_ff;
            end
            lo_in = lo_n;
            hi_in = hi_n;
            if (lo_n < hi_n) begin
               mid_n     = lo_n + ((hi_n - lo_n) >> 1);
               mem_re    = 1'b1;
               mem_raddr = mid_n;
               mid_in    = mid_n;
            end else begin
               fin_valid = 1'b1;
               fin_idx   = lo_n;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (fin_valid) begin
         mem_we    = 1'b1;
         mem_waddr = fin_idx;
         mem_wdata = key_ff;
         if (fin_idx == IW'(count_ff - CW'(1))) begin
            newest_in = key_ff;
         end
         rsp_strobe_in            = 1'b1;
         rsp_data_in.chain_index  = RSP_INDEX_BITS'(fin_idx);
         rsp_data_in.opened_chain = 1'b0;
         rsp_data_in.chain_count  = RSP_COUNT_BITS'(count_ff);
         rsp_data_in.overflow     = 1'b0;
         state_in                 = S_IDLE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         count_ff      <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff      <= key_in;
      newest_ff   <= newest_in;
      lo_ff       <= lo_in;
      hi_ff       <= hi_in;
      mid_ff      <= mid_in;
      rsp_data_ff <= rsp_data_in;
   end

   // single port tail memory, registered read
   always_ff @(posedge clock) begin
      if (mem_we) begin
         tails_mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rd_data_ff <= tails_mem[mem_raddr];
      end
   end

endmodule

[src/greedy_increasing_chain_layering.sv]
// top level of the greedy increasing-chain layering block
// Keys are split greedily into increasing chains (patience sorting). A transaction is taken
// when start is high and busy is low; busy only rises while the two-entry input queue is
// full. Each key yields exactly one result, shown on rsp_data for one cycle with rsp_strobe
// high; the receiver cannot stall, so it must take every result in that cycle. Results come
// out in input order. A key that opens a new chain or overflows is answered straight from
// the back end's idle state; any other key takes a binary search through the single-port
// tail memory, one registered read per step, then one write of the new tail, and the back
// end picks no new key from the queue until that search ends. The tail memory has no reset
// or clearing pass; only entries below the chain count are ever read. first_of_sequence
// drops all chains before its key is placed.
module greedy_increasing_chain_layering #(
   parameter int MAX_CHAINS = gicl_pkg::MAX_CHAINS_DEFAULT,
   parameter int KEY_BITS   = gicl_pkg::KEY_BITS_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  gicl_pkg::req_payload_type req_data,
   output logic                      rsp_strobe,
   output gicl_pkg::rsp_payload_type rsp_data
);
   import gicl_pkg::*;

   // queue head from front to back
   logic                q_valid;
   logic [KEY_BITS-1:0] q_key;
   logic                q_first;
   logic                q_pop;

   // front: handshake and queue, key trimmed to KEY_BITS
   gicl_front #(
      .KEY_BITS (KEY_BITS)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .busy     (busy),
      .req_data (req_data),
      .q_valid  (q_valid),
      .q_key    (q_key),
      .q_first  (q_first),
      .q_pop    (q_pop)
   );

   // back: classify against newest tail, search, update tails and emit result
   gicl_back #(
      .MAX_CHAINS (MAX_CHAINS),
      .KEY_BITS   (KEY_BITS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (q_valid),
      .q_key      (q_key),
      .q_first    (q_first),
      .q_pop      (q_pop),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

endmodule

[src/gicl_checker.sv]
// port-level checker for the chain layering block and its bind
module gicl_checker (
   input logic                      clock,
   input logic                      reset,
   input logic                      rsp_strobe,
   input gicl_pkg::rsp_payload_type rsp_data
);
   import gicl_pkg::*;

   // no result right after reset
   a_quiet_after_reset: assert property (@(posedge clock) reset |=> !rsp_strobe)
      else $error("result strobe right after reset");

   // overflow never opens a chain
   a_ovf_not_opened: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_data.overflow |-> !rsp_data.opened_chain)
      else $error("overflow with opened chain");

   // dropped key reports chain zero
   a_ovf_index: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_data.overflow |-> rsp_data.chain_index == '0)
      else $error("overflow with nonzero chain index");

   // a new chain is always the newest one
   a_open_is_newest: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_data.opened_chain |->
         rsp_data.chain_count[RSP_INDEX_BITS-1:0] ==
         rsp_data.chain_index + RSP_INDEX_BITS'(1))
      else $error("opened chain is not the newest");

endmodule

bind greedy_increasing_chain_layering gicl_checker u_gicl_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_strobe (rsp_strobe),
   .rsp_data   (rsp_data)
);

[dv/testbench.sv]
// self-checking testbench for the greedy increasing-chain layering block
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import gicl_pkg::*;

   localparam int MAX_CHAINS     = MAX_CHAINS_DEFAULT;
   localparam int RANDOM_KEYS    = 560;
   localparam int PHASE_KEYS     = RANDOM_KEYS / 4;
   localparam int FALL_KEYS      = 96;
   localparam int MISMATCH_SHOWN = 10;
   // a key's result comes back well within this once the back end is free
   localparam int DRAIN_CYCLES   = 30;
   // sender gaps at 88% idle stay far below this limit
   localparam int WATCHDOG_LIMIT = 5000;

   // shapes of a random key sequence
   typedef enum int {
      SEQ_SCATTERED,
      SEQ_FALLING,
      SEQ_CRAMPED,
      SEQ_RISING
   } seq_shape_type;

   // a key waiting in the driver queue, with the idling that applies to it
   typedef struct {
      req_payload_type payload;
      int unsigned     idle_pct;
      bit              wait_drain;
   } outgoing_key_type;

   logic            clock      = 1'b0;
   logic            reset      = 1'b1;
   logic            start      = 1'b0;
   req_payload_type req_data   = '0;
   logic            busy;
   logic            rsp_strobe;
   rsp_payload_type rsp_data;

   greedy_increasing_chain_layering u_top (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

   outgoing_key_type keys_to_send[$];
   rsp_payload_type  expected_placements[$];

   // shadow copy of the chain store
   logic [REQ_KEY_BITS-1:0] chain_tails [MAX_CHAINS];
   int                      open_chains = 0;

   int unsigned cur_idle_pct   = 0;
   int          mismatch_count = 0;
   int          quiet_cycles   = 0;
   // transactions offered by the driver and taken by the block
   int          offered_count  = 0;
   int          taken_count    = 0;

   initial begin
      forever #5 clock = ~clock;
   end

   // place one key the way the block should, updating the shadow store
   function automatic rsp_payload_type place_key(req_payload_type item);
      rsp_payload_type         placed;
      logic [REQ_KEY_BITS-1:0] k;
      int                      lo;
      int                      hi;
      int                      mid;
      placed = '0;
      k      = item.key;
      if (item.first_of_sequence) begin
         open_chains = 0;
      end
      if (open_chains == 0 || k <= chain_tails[open_chains-1]) begin
         // key not above the newest tail: open a chain, or drop it when full
         if (open_chains >= MAX_CHAINS) begin
            placed.overflow = 1'b1;
         end else begin
            placed.chain_index       = RSP_INDEX_BITS'(open_chains);
            placed.opened_chain      = 1'b1;
            chain_tails[open_chains] = k;
            open_chains++;
         end
      end else begin
         // tails never increase with index: find the leftmost one below the key
         lo = 0;
         hi = open_chains - 1;
         while (lo < hi) begin
            mid = lo + (hi - lo) / 2;
            if (chain_tails[mid] < k) begin
               hi = mid;
            end else begin
               lo = mid + 1;
            end
         end
         placed.chain_index = RSP_INDEX_BITS'(lo);
         chain_tails[lo]    = k;
      end
      placed.chain_count = RSP_COUNT_BITS'(open_chains);
      return placed;
   endfunction

   task automatic queue_key(input logic [REQ_KEY_BITS-1:0] k, input bit fos,
                            input bit drain);
      outgoing_key_type slot;
      slot.payload.key               = k;
      slot.payload.first_of_sequence = fos;
      slot.idle_pct                  = cur_idle_pct;
      slot.wait_drain                = drain;
      keys_to_send.insert(keys_to_send.size(), slot);
   endtask

   task automatic note_mismatch(input string field, input int unsigned want,
                                input int unsigned got);
      mismatch_count++;
      if (mismatch_count <= MISMATCH_SHOWN) begin
         $display("mismatch on %s: expected %0d, got %0d", field, want, got);
      end
   endtask

   // driver: inputs move only at the falling edge, each signal assigned at most once per edge
   always @(negedge clock) begin
      outgoing_key_type slot;
      if (reset) begin
         start <= 1'b0;
      end else if (!start || taken_count == offered_count) begin
         // previous transaction is done (or none was offered): pick the next one
         if (keys_to_send.size() == 0) begin
            start <= 1'b0;
         end else if (keys_to_send[0].wait_drain && expected_placements.size() != 0) begin
            // hold off until every outstanding result has come back
            start <= 1'b0;
         end else if ($urandom_range(99) < keys_to_send[0].idle_pct) begin
            start <= 1'b0;
         end else begin
            slot = keys_to_send.pop_front();
            req_data <= slot.payload;
            start    <= 1'b1;
            offered_count++;
         end
      end
   end

   // monitor: results are checked before the key taken on the same edge is predicted
   always @(posedge clock) begin
      rsp_payload_type want;
      bit              took_key;
      took_key = 1'b0;
      if (!reset) begin
         if (rsp_strobe) begin
            if (expected_placements.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= MISMATCH_SHOWN) begin
                  $display("result with no transaction outstanding: %p", rsp_data);
               end
            end else begin
               want = expected_placements.pop_front();
               if (rsp_data.chain_index !== want.chain_index) begin
                  note_mismatch("chain_index", want.chain_index, rsp_data.chain_index);
               end
               if (rsp_data.opened_chain !== want.opened_chain) begin
                  note_mismatch("opened_chain", want.opened_chain, rsp_data.opened_chain);
               end
               if (rsp_data.chain_count !== want.chain_count) begin
                  note_mismatch("chain_count", want.chain_count, rsp_data.chain_count);
               end
               if (rsp_data.overflow !== want.overflow) begin
                  note_mismatch("overflow", want.overflow, rsp_data.overflow);
               end
            end
         end
         if (start && !busy) begin
            took_key = 1'b1;
            taken_count++;
            expected_placements.insert(expected_placements.size(), place_key(req_data));
         end
         // watchdog: only counts while work is still outstanding
         if (took_key || rsp_strobe) begin
            quiet_cycles = 0;
         end else if (keys_to_send.size() != 0 || start ||
                      expected_placements.size() != 0) begin
            quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
               $display("watchdog expired after %0d idle cycles", quiet_cycles);
               $display("Testbench completed WITH ERRORS");
               $finish;
            end
         end
      end
   end

   // stimulus: directed corners, a long falling run with deep searches, then random sequences
   initial begin
      seq_shape_type           shape;
      logic [REQ_KEY_BITS-1:0] k;
      int                      seq_len;
      int                      sent_random;
      int                      step;
      bit                      fos;

      // --- directed corners, no idling ---
      cur_idle_pct = 0;
      queue_key(16'h0000, 1'b1, 1'b0);   // nothing open yet: chain 0
      queue_key(16'h0000, 1'b0, 1'b0);   // equal to newest tail: new chain
      queue_key(16'hFFFF, 1'b0, 1'b0);   // top key: replaces tail of chain 0
      queue_key(16'hFFFF, 1'b0, 1'b0);   // equal keys again, search with strict compare
      queue_key(16'h0000, 1'b0, 1'b0);
      queue_key(16'd100,  1'b1, 1'b0);   // restart mid-stream
      queue_key(16'd50,   1'b0, 1'b0);
      queue_key(16'd75,   1'b0, 1'b0);
      queue_key(16'd60,   1'b0, 1'b0);
      queue_key(16'd200,  1'b0, 1'b0);
      queue_key(16'd10,   1'b0, 1'b0);
      queue_key(16'd10,   1'b0, 1'b0);
      queue_key(16'd300,  1'b0, 1'b0);
      queue_key(16'd5,    1'b0, 1'b0);
      queue_key(16'd55,   1'b0, 1'b0);
      queue_key(16'hAAAA, 1'b1, 1'b0);   // alternating bit patterns
      queue_key(16'h5555, 1'b0, 1'b0);
      queue_key(16'h8000, 1'b0, 1'b0);
      queue_key(16'h0001, 1'b0, 1'b0);
      queue_key(16'h7FFF, 1'b0, 1'b0);
      queue_key(16'hFFFE, 1'b0, 1'b0);

      // --- a falling run opens many chains ---
      for (int i = 0; i < FALL_KEYS; i++) begin
         queue_key(REQ_KEY_BITS'(60000 - i * 50), i == 0, i == 0);
      end
      queue_key(REQ_KEY_BITS'(60000 - (FALL_KEYS - 1) * 50), 1'b0, 1'b0); // equal to newest
      queue_key(16'h0000, 1'b0, 1'b0);                                     // below newest
      // keys above the newest tail search across the whole store
      for (int i = 0; i < 20; i++) begin
         queue_key(REQ_KEY_BITS'($urandom_range(8000, 65535)), 1'b0, 1'b0);
      end

      // --- random sequences, idling changes phase every quarter ---
      sent_random = 0;
      while (sent_random < RANDOM_KEYS) begin
         case (sent_random / PHASE_KEYS)
            0:       cur_idle_pct = 0;
            1:       cur_idle_pct = 88;
            2:       cur_idle_pct = 0;
            default: cur_idle_pct = 19;
         endcase
         shape   = seq_shape_type'($urandom_range(SEQ_RISING, SEQ_SCATTERED));
         seq_len = ($urandom_range(7) == 0) ? $urandom_range(100, 200) : $urandom_range(1, 40);
         k       = REQ_KEY_BITS'($urandom);
         for (int i = 0; i < seq_len && sent_random < RANDOM_KEYS; i++) begin
            case (shape)
               SEQ_FALLING: begin
                  step = $urandom_range(1, 40);
                  k    = (k < step || $urandom_range(5) == 0) ? REQ_KEY_BITS'($urandom)
                                                             : REQ_KEY_BITS'(k - step);
               end
               SEQ_RISING: begin
                  step = $urandom_range(1, 600);
                  k    = (k > 16'hFFFF - step || $urandom_range(5) == 0)
                         ? REQ_KEY_BITS'($urandom) : REQ_KEY_BITS'(k + step);
               end
               SEQ_CRAMPED: k = REQ_KEY_BITS'($urandom_range(15));
               default:     k = REQ_KEY_BITS'($urandom);
            endcase
            // a sequence starts with a clear; stray clears inside are noise
            fos = (i == 0) || ($urandom_range(49) == 0);
            // a sequence starting near the head of a phase, and now and then another, waits for a drain
            queue_key(k, fos, (i == 0) && ((sent_random % PHASE_KEYS) < 3 ||
                                           $urandom_range(19) == 0));
            sent_random++;
         end
      end

      // --- reset, released at a falling edge ---
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // wait until every key has gone out and every result has come back
      while (keys_to_send.size() != 0 || start || expected_placements.size() != 0) begin
         @(posedge clock);
      end
      // let any stray result show up before the verdict
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

[sim.f]
src/gicl_pkg.sv
src/gicl_front.sv
src/gicl_back.sv
src/greedy_increasing_chain_layering.sv
src/gicl_checker.sv
dv/testbench.sv
